FILE: src/cpp_pkg.sv
package cpp_pkg;

    localparam int COORD_W     = 56;
    localparam int PROD_W      = 53;
    localparam int NORM_FRAC   = 24;
    localparam int K_FRAC      = 28;
    localparam int QUOT_W      = 31;
    localparam int REM_W       = 88;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;
    localparam logic [62:0] ROT0_RESET  = 63'h0000_0000_0008_0000;
    localparam logic [62:0] ROT1_RESET  = 63'h0000_0100_0000_0000;
    localparam logic [62:0] ROT2_RESET  = 63'h2000_0000_0000_0000;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEPTH = 2'd1;
    localparam logic [1:0] STATUS_SAT        = 2'd2;

    typedef enum logic [2:0] {
        REG_FOCAL,
        REG_DIST,
        REG_ROT0,
        REG_ROT1,
        REG_ROT2,
        REG_TRANS_XY,
        REG_TRANS_Z,
        REG_PRINCIPAL
    } cfg_reg_t;

    typedef struct packed {
        logic                      zero;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } cam_item_t;

    typedef struct packed {
        logic              zero;
        logic              ovx;
        logic              ovy;
        logic              sx;
        logic              sy;
        logic [REM_W-1:0]  rx;
        logic [REM_W-1:0]  ry;
        logic [QUOT_W-1:0] qx;
        logic [QUOT_W-1:0] qy;
        logic [COORD_W-1:0] mb;
    } div_t;

    typedef struct packed {
        logic              flag;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t res;
        res.flag = 1'b0;
        res.val  = v[31:0];
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            res.flag = 1'b1;
            res.val  = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            res.flag = 1'b1;
            res.val  = 32'sh8000_0000;
        end
        return res;
    endfunction

endpackage

FILE: src/cpp_front.sv
module cpp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          point_x,
    input  logic signed [31:0]          point_y,
    input  logic signed [31:0]          point_z,
    input  logic [62:0]                 rot0,
    input  logic [62:0]                 rot1,
    input  logic [62:0]                 rot2,
    input  logic signed [31:0]          trans_x,
    input  logic signed [31:0]          trans_y,
    input  logic signed [31:0]          trans_z,
    input  logic                        space,
    output logic                        push,
    output cpp_pkg::cam_item_t          push_item
);

    logic               s1_valid_reg;
    logic signed [31:0] p_reg [3];
    logic               s2_valid_reg;
    logic signed [cpp_pkg::PROD_W-1:0] prod_reg [3][3];
    logic [62:0]        rows [3];
    logic signed [cpp_pkg::COORD_W-1:0] sums [3];
    logic signed [31:0] trans [3];

    assign in_stall = !space;
    assign push     = s2_valid_reg && space;
    assign rows[0]  = rot0;
    assign rows[1]  = rot1;
    assign rows[2]  = rot2;
    assign trans[0] = trans_x;
    assign trans[1] = trans_y;
    assign trans[2] = trans_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (space)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (space)
        begin
            p_reg[0] <= point_x;
            p_reg[1] <= point_y;
            p_reg[2] <= point_z;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed(rows[i][21*j +: 21]) * p_reg[j];
                end
            end
        end
    end

    // translation is Q16.16, products are Q.35
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sums[i] = cpp_pkg::COORD_W'(prod_reg[i][0]) + cpp_pkg::COORD_W'(prod_reg[i][1])
                    + cpp_pkg::COORD_W'(prod_reg[i][2])
                    + (cpp_pkg::COORD_W'(trans[i]) <<< 19);
        end
        push_item.cx   = sums[0];
        push_item.cy   = sums[1];
        push_item.cz   = sums[2];
        push_item.zero = (sums[2] == '0);
    end

endmodule

FILE: src/cpp_queue.sv
module cpp_queue #(
    parameter int DEPTH = cpp_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cpp_pkg::cam_item_t push_item,
    input  logic               pop,
    output logic               not_empty,
    output logic               space,
    output cpp_pkg::cam_item_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpp_pkg::cam_item_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign space     = (count_reg != CNT_W'(DEPTH)) || pop;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/cpp_back.sv
module cpp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cpp_pkg::cam_item_t q_item,
    output logic               pop,
    input  logic [31:0]        focal,
    input  logic signed [31:0] k1,
    input  logic signed [31:0] k2,
    input  logic signed [31:0] u0,
    input  logic signed [31:0] v0,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] image_u,
    output logic signed [31:0] image_v,
    output logic [1:0]         status
);

    localparam int QW = cpp_pkg::QUOT_W;
    localparam int RW = cpp_pkg::REM_W;
    localparam int CW = cpp_pkg::COORD_W;

    logic en;
    logic b0_valid_reg;
    cpp_pkg::div_t b0_reg, b0_next;
    logic div_valid_reg [QW];
    cpp_pkg::div_t div_reg [QW];
    cpp_pkg::div_t div_src [QW];
    cpp_pkg::div_t div_next [QW];

    logic [9:0] pv_reg;
    logic zero_reg [9];
    logic sat_reg  [9];
    logic signed [31:0] nx_reg [8];
    logic signed [31:0] ny_reg [8];
    logic [61:0] sqx_reg, sqy_reg;
    logic [31:0] r2_reg, r2b_reg, r2c_reg, r4_reg;
    logic [63:0] r2sq_reg;
    logic signed [64:0] t1_reg, t2_reg, fd_reg;
    logic signed [31:0] d_reg, g_reg;
    logic signed [63:0] gx_reg, gy_reg;
    logic signed [31:0] u_reg, v_reg;
    logic [1:0] status_reg;

    logic [CW-1:0] ma_x, ma_y, ma_z;
    cpp_pkg::div_t last;
    logic [QW-1:0] qx_eff, qy_eff;
    logic [62:0] sq_sum;
    logic [38:0] r2_wide;
    logic [39:0] r4_wide;
    logic signed [38:0] d_sum;
    cpp_pkg::sat_t d_sat, g_sat, u_sat, v_sat;

    assign en        = !pv_reg[9] || !out_stall;
    assign pop       = en && q_valid;
    assign out_valid = pv_reg[9];
    assign image_u   = u_reg;
    assign image_v   = v_reg;
    assign status    = status_reg;

    always_comb
    begin
        ma_x = q_item.cx[CW-1] ? CW'(-q_item.cx) : CW'(q_item.cx);
        ma_y = q_item.cy[CW-1] ? CW'(-q_item.cy) : CW'(q_item.cy);
        ma_z = q_item.cz[CW-1] ? CW'(-q_item.cz) : CW'(q_item.cz);
        b0_next.zero = q_item.zero;
        b0_next.sx   = q_item.cx[CW-1] ^ q_item.cz[CW-1];
        b0_next.sy   = q_item.cy[CW-1] ^ q_item.cz[CW-1];
        // quotient would reach 2^31
        b0_next.ovx  = {7'b0, ma_x} >= {ma_z, 7'b0};
        b0_next.ovy  = {7'b0, ma_y} >= {ma_z, 7'b0};
        b0_next.rx   = RW'(ma_x) << cpp_pkg::NORM_FRAC;
        b0_next.ry   = RW'(ma_y) << cpp_pkg::NORM_FRAC;
        b0_next.qx   = '0;
        b0_next.qy   = '0;
        b0_next.mb   = ma_z;
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        logic [RW-1:0] dsh;
        if (i == 0)
        begin : g_first
            assign div_src[i] = b0_reg;
        end
        else
        begin : g_rest
            assign div_src[i] = div_reg[i-1];
        end

        always_comb
        begin
            dsh = RW'(div_src[i].mb) << (QW - 1 - i);
            div_next[i] = div_src[i];
            if (div_src[i].rx >= dsh)
            begin
                div_next[i].rx = div_src[i].rx - dsh;
                div_next[i].qx[QW-1-i] = 1'b1;
            end
            if (div_src[i].ry >= dsh)
            begin
                div_next[i].ry = div_src[i].ry - dsh;
                div_next[i].qy[QW-1-i] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                div_valid_reg[i] <= (i == 0) ? b0_valid_reg : div_valid_reg[(i == 0) ? 0 : i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    always_comb
    begin
        last    = div_reg[QW-1];
        qx_eff  = last.ovx ? '1 : last.qx;
        qy_eff  = last.ovy ? '1 : last.qy;
        sq_sum  = 63'(sqx_reg) + 63'(sqy_reg);
        r2_wide = sq_sum[62:24];
        r4_wide = r2sq_reg[63:24];
        d_sum   = 39'($signed(t1_reg[64:28])) + 39'($signed(t2_reg[64:28]))
                + 39'(1 << cpp_pkg::NORM_FRAC);
        d_sat   = cpp_pkg::sat32(64'(d_sum));
        g_sat   = cpp_pkg::sat32(64'($signed(fd_reg[64:24])));
        u_sat   = cpp_pkg::sat32(64'($signed(gx_reg[63:24])) + 64'(u0));
        v_sat   = cpp_pkg::sat32(64'($signed(gy_reg[63:24])) + 64'(v0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
            pv_reg       <= '0;
        end
        else if (en)
        begin
            b0_valid_reg <= q_valid;
            pv_reg       <= {pv_reg[8:0], div_valid_reg[QW-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg <= b0_next;
            // p1: normalized point and squares
            zero_reg[0] <= last.zero;
            sat_reg[0]  <= last.ovx || last.ovy;
            nx_reg[0]   <= last.sx ? -$signed({1'b0, qx_eff}) : $signed({1'b0, qx_eff});
            ny_reg[0]   <= last.sy ? -$signed({1'b0, qy_eff}) : $signed({1'b0, qy_eff});
            sqx_reg     <= qx_eff * qx_eff;
            sqy_reg     <= qy_eff * qy_eff;
            for (int i = 1; i < 9; i++)
            begin
                zero_reg[i] <= zero_reg[i-1];
            end
            for (int i = 1; i < 8; i++)
            begin
                nx_reg[i] <= nx_reg[i-1];
                ny_reg[i] <= ny_reg[i-1];
            end
            // p2: r2
            r2_reg     <= (r2_wide[38:32] != '0) ? '1 : r2_wide[31:0];
            sat_reg[1] <= sat_reg[0] || (r2_wide[38:32] != '0);
            // p3
            r2sq_reg   <= r2_reg * r2_reg;
            r2b_reg    <= r2_reg;
            sat_reg[2] <= sat_reg[1];
            // p4: r4
            r4_reg     <= (r4_wide[39:32] != '0) ? '1 : r4_wide[31:0];
            r2c_reg    <= r2b_reg;
            sat_reg[3] <= sat_reg[2] || (r4_wide[39:32] != '0);
            // p5: distortion terms
            t1_reg     <= k1 * $signed({1'b0, r2c_reg});
            t2_reg     <= k2 * $signed({1'b0, r4_reg});
            sat_reg[4] <= sat_reg[3];
            // p6
            d_reg      <= d_sat.val;
            sat_reg[5] <= sat_reg[4] || d_sat.flag;
            // p7
            fd_reg     <= $signed({1'b0, focal}) * d_reg;
            sat_reg[6] <= sat_reg[5];
            // p8
            g_reg      <= g_sat.val;
            sat_reg[7] <= sat_reg[6] || g_sat.flag;
            // p9
            gx_reg     <= g_reg * nx_reg[7];
            gy_reg     <= g_reg * ny_reg[7];
            sat_reg[8] <= sat_reg[7];
            // output register
            if (zero_reg[8])
            begin
                u_reg      <= '0;
                v_reg      <= '0;
                status_reg <= cpp_pkg::STATUS_ZERO_DEPTH;
            end
            else
            begin
                u_reg      <= u_sat.val;
                v_reg      <= v_sat.val;
                status_reg <= (sat_reg[8] || u_sat.flag || v_sat.flag) ?
                              cpp_pkg::STATUS_SAT : cpp_pkg::STATUS_OK;
            end
        end
    end

endmodule

FILE: src/camera_point_projection_unit.sv
// Pinhole projection with k1/k2 radial distortion. One point is taken per clock
// while in_stall is low, and one (image_u, image_v, status) result leaves per
// point, in order. An accepted point passes the two camera transform registers,
// one queue slot, then the back end with a setup register, the 31-stage
// restoring divider (one quotient bit per stage) and ten multiply and saturate
// stages. Output stall holds the back end; the four-entry queue absorbs it
// before in_stall rises. Configuration writes must only be issued while no point
// is in flight.
module camera_point_projection_unit #(
    parameter int QUEUE_DEPTH = cpp_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] image_u,
    output logic signed [31:0] image_v,
    output logic [1:0]         status
);

    logic [31:0] focal_reg;
    logic [63:0] dist_reg;
    logic [62:0] rot0_reg, rot1_reg, rot2_reg;
    logic [63:0] trans_xy_reg;
    logic [31:0] trans_z_reg;
    logic [63:0] principal_reg;

    logic               space, push, pop, not_empty;
    cpp_pkg::cam_item_t push_item, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg     <= cpp_pkg::FOCAL_RESET;
            dist_reg      <= '0;
            rot0_reg      <= cpp_pkg::ROT0_RESET;
            rot1_reg      <= cpp_pkg::ROT1_RESET;
            rot2_reg      <= cpp_pkg::ROT2_RESET;
            trans_xy_reg  <= '0;
            trans_z_reg   <= '0;
            principal_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cpp_pkg::cfg_reg_t'(cfg_index))
                cpp_pkg::REG_FOCAL:     focal_reg     <= cfg_data[31:0];
                cpp_pkg::REG_DIST:      dist_reg      <= cfg_data;
                cpp_pkg::REG_ROT0:      rot0_reg      <= cfg_data[62:0];
                cpp_pkg::REG_ROT1:      rot1_reg      <= cfg_data[62:0];
                cpp_pkg::REG_ROT2:      rot2_reg      <= cfg_data[62:0];
                cpp_pkg::REG_TRANS_XY:  trans_xy_reg  <= cfg_data;
                cpp_pkg::REG_TRANS_Z:   trans_z_reg   <= cfg_data[31:0];
                cpp_pkg::REG_PRINCIPAL: principal_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .rot0      (rot0_reg),
        .rot1      (rot1_reg),
        .rot2      (rot2_reg),
        .trans_x   ($signed(trans_xy_reg[31:0])),
        .trans_y   ($signed(trans_xy_reg[63:32])),
        .trans_z   ($signed(trans_z_reg)),
        .space     (space),
        .push      (push),
        .push_item (push_item)
    );

    cpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (not_empty),
        .space     (space),
        .head      (head)
    );

    cpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_item    (head),
        .pop       (pop),
        .focal     (focal_reg),
        .k1        ($signed(dist_reg[31:0])),
        .k2        ($signed(dist_reg[63:32])),
        .u0        ($signed(principal_reg[31:0])),
        .v0        ($signed(principal_reg[63:32])),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .image_u   (image_u),
        .image_v   (image_v),
        .status    (status)
    );

endmodule
